FILE: rtl/zero_cross_frequency_meter_assert.svh
// assertion macros for the zero crossing frequency meter checker
// no dependencies; included by the checker file
`ifndef ZERO_CROSS_FREQUENCY_METER_ASSERT_SVH
`define ZERO_CROSS_FREQUENCY_METER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ZCFM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zcfm check failed");

// next-cycle implication, disabled while reset is low
`define ZCFM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zcfm check failed");

`endif

FILE: rtl/zcfm_pkg.sv
// shared constants and types of the zero crossing frequency meter
// no dependencies; imported by every module of the block
package zcfm_pkg;

    localparam int SAMPLE_W      = 14;
    localparam int HYST_W        = 13;
    localparam int FS_W          = 20;
    localparam int INDEX_BITS    = 16;
    localparam int FRACTION_BITS = 16;
    localparam int MAX_CROSSINGS = 128;
    localparam int COUNT_W       = 8;
    localparam int TIME_W        = INDEX_BITS + FRACTION_BITS + 1;
    localparam int TSUM_W        = TIME_W + 1;
    localparam int FREQ_W        = 32;
    localparam int OUT_FRAC      = 8;
    localparam int FREQ_SHIFT    = FRACTION_BITS + OUT_FRAC;
    localparam int MUL_W         = COUNT_W - 1 + FS_W;
    localparam int NUM_W         = MUL_W + FREQ_SHIFT;
    localparam int DVD_W         = NUM_W + 1;
    localparam int FRAC_Q_W      = SAMPLE_W + FRACTION_BITS;

    // shared restoring divider
    localparam int DIV_Q_W   = 32;
    localparam int DIV_REM_W = TIME_W + 1;
    localparam int DIV_STEPS = DIV_Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_HYSTERESIS  = 1'b1;
    localparam logic [FS_W-1:0]   FS_RESET   = FS_W'(100000);
    localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(10);

    typedef struct packed {
        logic [FS_W-1:0]   sample_rate_hz;
        logic [HYST_W-1:0] hysteresis_level;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_Q_W-1:0]   dividend_lo;
        logic [DIV_REM_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/zcfm_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on zcfm_pkg
module zcfm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zcfm_pkg::t_div_cmd  i_cmd,
    output zcfm_pkg::t_div_rsp  o_rsp
);
    import zcfm_pkg::*;

    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_REM_W-1:0] r_div;
    logic [DIV_Q_W-1:0]   r_lo;
    logic [DIV_Q_W-1:0]   r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_REM_W-1:0] shifted;
    logic [DIV_REM_W-1:0] reduced;
    logic                 fits;

    always_comb begin
        shifted = {r_rem[DIV_REM_W-2:0], r_lo[DIV_Q_W-1]};
        fits    = (shifted >= r_div);
        reduced = shifted - r_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_cmd.rem_init;
            r_lo  <= i_cmd.dividend_lo;
            r_div <= i_cmd.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? reduced : shifted;
            r_lo  <= {r_lo[DIV_Q_W-2:0], 1'b0};
            r_q   <= {r_q[DIV_Q_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

FILE: rtl/zcfm_regs.sv
// apb register file: sample rate and hysteresis level
// depends on zcfm_pkg
module zcfm_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [zcfm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [zcfm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [zcfm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output zcfm_pkg::t_cfg                      o_cfg
);
    import zcfm_pkg::*;

    logic [FS_W-1:0]   r_fs;
    logic [HYST_W-1:0] r_hyst;
    logic              wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs   <= FS_RESET;
            r_hyst <= HYST_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SAMPLE_RATE: r_fs   <= pwdata[FS_W-1:0];
                REG_HYSTERESIS:  r_hyst <= pwdata[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SAMPLE_RATE: prdata = APB_DATA_W'(r_fs);
            REG_HYSTERESIS:  prdata = APB_DATA_W'(r_hyst);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.sample_rate_hz   = r_fs;
    assign o_cfg.hysteresis_level = r_hyst;

endmodule

FILE: rtl/zero_cross_frequency_meter.sv
// top level of the zero crossing frequency meter: sequencer, crossing state, output register
// depends on zcfm_pkg, zcfm_div and zcfm_regs
//
// Takes one signed 14-bit sample per request and tracks rising crossings with a
// symmetric hysteresis band. Each crossing time is interpolated to 16 fraction bits
// between the two samples around it; only the first and the last crossing times and
// a count (stopping at 128) are kept. A request marked last_of_buffer produces one
// result: frequency in unsigned Q24.8 Hz, rounded and saturated, with measure_valid
// low (and frequency 0) when there were fewer than two crossings or no positive
// interval. A sample with an interpolated crossing runs the interpolation divide (a
// crossing on a repeated sample takes the sample's own time instead), and a last
// sample runs the frequency divide unless its result is invalid or saturated; a
// request may also wait for the output register to free up. Both long paths run
// through the one 32-step restoring divider, one quotient bit per cycle.
// The input side is not ready while a request is in progress, but a finished result
// waits in its own output register so the next sample can be taken meanwhile.
// Registers sit on an apb port: sample_rate_hz at 0x0, hysteresis_level at 0x4; write
// them only while the block is idle.
module zero_cross_frequency_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [zcfm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_first_of_buffer,
    input  logic                                i_last_of_buffer,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [zcfm_pkg::FREQ_W-1:0]         o_frequency_q8,
    output logic                                o_measure_valid,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [zcfm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [zcfm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [zcfm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import zcfm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,    // waiting for a sample
        ST_EVAL,    // hysteresis update, crossing detect
        ST_XDIV,    // interpolation divide running
        ST_STORE,   // record crossing time
        ST_FINISH,  // keep sample as previous, branch on last
        ST_FMUL,    // (count-1)*fs and crossing interval
        ST_FPREP,   // validity and rounded dividend
        ST_FCHK,    // overflow test, start frequency divide
        ST_FDIV,    // frequency divide running
        ST_OUT      // hand result to output register
    } t_state;

    t_cfg     cfg;
    t_div_cmd div_cmd;
    t_div_rsp div_rsp;

    t_state r_state;

    // measurement state
    logic                      r_level;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [INDEX_BITS-1:0]     r_index;
    logic [COUNT_W-1:0]        r_count;
    logic [TIME_W-1:0]         r_first_t;
    logic [TIME_W-1:0]         r_last_t;

    // request in flight
    logic signed [SAMPLE_W-1:0] r_cur;
    logic                      r_first;
    logic                      r_last;
    logic                      r_neg;
    logic [TIME_W-1:0]         r_cross_t;
    logic [MUL_W-1:0]          r_prod;
    logic [TIME_W:0]           r_interval;
    logic [TIME_W-1:0]         r_d;
    logic [DVD_W-1:0]          r_dividend;
    logic [FREQ_W-1:0]         r_res_freq;
    logic                      r_res_valid;

    // output register
    logic                      r_out_valid;
    logic [FREQ_W-1:0]         r_out_freq;
    logic                      r_out_mvalid;

    // eval-side arithmetic, all on sign-extended samples
    logic signed [SAMPLE_W:0]  cur_x;
    logic signed [SAMPLE_W:0]  prev_x;
    logic signed [SAMPLE_W:0]  h_pos;
    logic signed [SAMPLE_W:0]  h_neg;
    logic signed [SAMPLE_W:0]  diff_x;
    logic signed [SAMPLE_W:0]  num_x;
    logic [SAMPLE_W:0]         num_abs;
    logic [SAMPLE_W:0]         diff_abs;
    logic [SAMPLE_W-1:0]       an;
    logic [SAMPLE_W-1:0]       ad;
    logic                      above;
    logic                      below;
    logic                      count_ok;
    logic                      cross_hit;
    logic [INDEX_BITS-1:0]     idx_inc;
    logic [TIME_W-1:0]         t_same;

    // interpolated time after the divide
    logic [INDEX_BITS-1:0]     idx_m1;
    logic [FRAC_Q_W:0]         frac_mag;
    logic [FRAC_Q_W:0]         frac;
    logic [TSUM_W-1:0]         t_sum;
    logic [TIME_W-1:0]         t_div;

    // frequency side
    logic [COUNT_W-2:0]        cnt_m1;
    logic                      meas_ok;
    logic                      freq_ovf;
    logic                      take_out;

    zcfm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    zcfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        cur_x    = {r_cur[SAMPLE_W-1], r_cur};
        prev_x   = {r_prev[SAMPLE_W-1], r_prev};
        h_pos    = $signed({2'b00, cfg.hysteresis_level});
        h_neg    = -h_pos;
        diff_x   = cur_x - prev_x;
        num_x    = -prev_x;
        num_abs  = num_x[SAMPLE_W] ? -num_x : num_x;
        diff_abs = diff_x[SAMPLE_W] ? -diff_x : diff_x;
        // |prev| <= 8192 and |cur-prev| <= 16383 both fit the sample width
        an       = num_abs[SAMPLE_W-1:0];
        ad       = diff_abs[SAMPLE_W-1:0];
        above    = (cur_x > h_pos);
        below    = (cur_x < h_neg);
        count_ok = (r_count < COUNT_W'(MAX_CROSSINGS));
        cross_hit = !r_first && count_ok && !r_level && above;
        idx_inc  = (r_index != '1) ? r_index + 1'b1 : r_index;
        // equal samples: the crossing sits on the sample itself
        t_same   = {1'b0, idx_inc, {FRACTION_BITS{1'b0}}};
    end

    // index was already advanced in eval, so base is index-1
    always_comb begin
        idx_m1   = r_index - 1'b1;
        frac_mag = {1'b0, div_rsp.quotient[FRAC_Q_W-1:0]};
        frac     = r_neg ? -frac_mag : frac_mag;
        t_sum    = {2'b00, idx_m1, {FRACTION_BITS{1'b0}}}
                 + {{(TSUM_W-FRAC_Q_W-1){frac[FRAC_Q_W]}}, frac};
        // saturate to the signed time width
        if (!t_sum[TSUM_W-1] && t_sum[TSUM_W-2]) begin
            t_div = {1'b0, {(TIME_W-1){1'b1}}};
        end else if (t_sum[TSUM_W-1] && !t_sum[TSUM_W-2]) begin
            t_div = {1'b1, {(TIME_W-1){1'b0}}};
        end else begin
            t_div = t_sum[TIME_W-1:0];
        end
    end

    always_comb begin
        // count of 1..128 gives 0..127; a count of 0 never reaches a valid result
        cnt_m1   = r_count[COUNT_W-2:0] - 1'b1;
        meas_ok  = (r_count >= COUNT_W'(2)) && !r_interval[TIME_W] && (r_interval != '0);
        // quotient reaches 2^32 exactly when the upper dividend bits reach the divisor
        freq_ovf = (DIV_REM_W'(r_dividend[DVD_W-1:DIV_Q_W]) >= DIV_REM_W'(r_d));
        take_out = !r_out_valid || i_out_ready;
    end

    // divider requests: interpolation from eval, frequency from the overflow check
    always_comb begin
        div_cmd = '0;
        if (r_state == ST_EVAL && cross_hit && diff_x != '0) begin
            div_cmd.start       = 1'b1;
            div_cmd.rem_init    = '0;
            div_cmd.dividend_lo = DIV_Q_W'({an, {FRACTION_BITS{1'b0}}});
            div_cmd.divisor     = DIV_REM_W'(ad);
        end else if (r_state == ST_FCHK && !freq_ovf) begin
            div_cmd.start       = 1'b1;
            div_cmd.rem_init    = DIV_REM_W'(r_dividend[DVD_W-1:DIV_Q_W]);
            div_cmd.dividend_lo = r_dividend[DIV_Q_W-1:0];
            div_cmd.divisor     = DIV_REM_W'(r_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= 1'b0;
            r_prev      <= '0;
            r_index     <= '0;
            r_count     <= '0;
            r_first_t   <= '0;
            r_last_t    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result leaves when the consumer takes it; in ST_OUT the reload decides
            if (r_out_valid && i_out_ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cur   <= i_sample;
                        r_first <= i_first_of_buffer;
                        r_last  <= i_last_of_buffer;
                        r_state <= ST_EVAL;
                    end
                end

                ST_EVAL: begin
                    r_neg <= num_x[SAMPLE_W] ^ diff_x[SAMPLE_W];
                    if (r_first) begin
                        // new buffer: level from this sample, index, count and crossing times cleared
                        r_level   <= above;
                        r_index   <= '0;
                        r_count   <= '0;
                        r_first_t <= '0;
                        r_last_t  <= '0;
                        r_state   <= ST_FINISH;
                    end else begin
                        r_index <= idx_inc;
                        if (cross_hit) begin
                            if (diff_x == '0) begin
                                r_cross_t <= t_same;
                                r_state   <= ST_STORE;
                            end else begin
                                r_state <= ST_XDIV;
                            end
                        end else begin
                            if (count_ok && r_level && below) begin
                                r_level <= 1'b0;
                            end
                            r_state <= ST_FINISH;
                        end
                    end
                end

                ST_XDIV: begin
                    if (div_rsp.done) begin
                        r_cross_t <= t_div;
                        r_state   <= ST_STORE;
                    end
                end

                ST_STORE: begin
                    r_level <= 1'b1;
                    if (r_count == '0) begin
                        r_first_t <= r_cross_t;
                    end
                    r_last_t <= r_cross_t;
                    r_count  <= r_count + 1'b1;
                    r_state  <= ST_FINISH;
                end

                ST_FINISH: begin
                    r_prev  <= r_cur;
                    r_state <= r_last ? ST_FMUL : ST_IDLE;
                end

                ST_FMUL: begin
                    r_prod     <= MUL_W'(cnt_m1) * MUL_W'(cfg.sample_rate_hz);
                    r_interval <= {r_last_t[TIME_W-1], r_last_t}
                                - {r_first_t[TIME_W-1], r_first_t};
                    r_state    <= ST_FPREP;
                end

                ST_FPREP: begin
                    if (meas_ok) begin
                        r_d        <= r_interval[TIME_W-1:0];
                        // add half the divisor for round to nearest
                        r_dividend <= {1'b0, r_prod, {FREQ_SHIFT{1'b0}}}
                                    + DVD_W'(r_interval[TIME_W-1:1]);
                        r_state    <= ST_FCHK;
                    end else begin
                        r_res_freq  <= '0;
                        r_res_valid <= 1'b0;
                        r_state     <= ST_OUT;
                    end
                end

                ST_FCHK: begin
                    if (freq_ovf) begin
                        r_res_freq  <= '1;
                        r_res_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end else begin
                        r_state <= ST_FDIV;
                    end
                end

                ST_FDIV: begin
                    if (div_rsp.done) begin
                        r_res_freq  <= div_rsp.quotient;
                        r_res_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end
                end

                ST_OUT: begin
                    // wait for a free output register
                    if (take_out) begin
                        r_out_valid  <= 1'b1;
                        r_out_freq   <= r_res_freq;
                        r_out_mvalid <= r_res_valid;
                        r_state      <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_frequency_q8  = r_out_freq;
    assign o_measure_valid = r_out_mvalid;

endmodule

FILE: rtl/zcfm_checker.sv
// port-level checks for the zero crossing frequency meter, bound to the top level
// depends on zcfm_pkg and zero_cross_frequency_meter_assert.svh
`include "zero_cross_frequency_meter_assert.svh"

module zcfm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [zcfm_pkg::FREQ_W-1:0]         o_frequency_q8,
    input logic                                o_measure_valid,
    input logic                                psel,
    input logic                                penable,
    input logic                                pready
);
    import zcfm_pkg::*;

    // a stalled result keeps its payload
    `ZCFM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_frequency_q8) && $stable(o_measure_valid))

    // an invalid measurement always reads as zero hertz
    `ZCFM_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, o_out_valid && !o_measure_valid, o_frequency_q8 == '0)

    // after each accepted request the sequencer is busy in the next cycle
    `ZCFM_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a new result appears only when the input side is not ready or was not ready just before
    `ZCFM_ASSERT_IMP(a_result_cause, i_clk, i_rst_n, $rose(o_out_valid), !o_in_ready || $past(!o_in_ready))

    // register port never stretches an access
    `ZCFM_ASSERT_IMP(a_pready_high, i_clk, i_rst_n, psel && penable, pready)

endmodule

bind zero_cross_frequency_meter zcfm_checker u_zcfm_checker (.*);
